// ----- rtl/tmq_pkg.sv -----
// Shared types, request codes and a time compare helper for the timer event queue.
package tmq_pkg;

   localparam int unsigned ID_W       = 4;
   localparam int unsigned ID_COUNT   = 16;
   localparam logic [31:0] EMPTY_HALF = 32'h7fff_ffff;

   localparam logic [1:0] REQ_SCHEDULE = 2'd0;
   localparam logic [1:0] REQ_CANCEL   = 2'd1;
   localparam logic [1:0] REQ_STEP     = 2'd2;

   // One queue entry as held by a cell.
   typedef struct packed {
      logic            valid;
      logic [ID_W-1:0] id;
      logic [31:0]     due;
      logic [15:0]     action;
      logic [31:0]     context_word;
      logic [31:0]     flags;
   } entry_type;

   // Load controls for one cell.
   typedef struct packed {
      logic load_next;
      logic load_carry;
   } cell_ctl_type;

   // a is before b when the signed 32-bit difference a - b is negative
   function automatic logic is_before(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] diff;
      diff = a - b;
      return diff[31];
   endfunction

endpackage

// ----- rtl/tmq_cell.sv -----
// One position of the sorted queue: holds an entry, takes its neighbor's or the carry.
module tmq_cell
   import tmq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  entry_type    next_entry,
   input  entry_type    carry_entry,
   output entry_type    entry
);

   entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.load_next) begin
         entry_in = next_entry;
      end else if (ctl.load_carry) begin
         entry_in = carry_entry;
      end
      // only the occupancy bit is cleared; payload needs no reset
      if (reset) begin
         entry_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ----- rtl/timer_event_queue_core.sv -----
// Top level of the timer event queue: request sequencer, cell chain and result register.
//
// Requests arrive on req_* (tuser = request kind), one result per request leaves on rsp_*.
// The queue is a chain of NUM_TASKS cells kept in due-time order, head in cell 0,
// occupied cells packed at the front.
// Step: compares the head with now_time and pops it if due; the result is registered.
// Cancel: if the task is queued, a walk token moves down the chain one cell per cycle,
// pulling each cell from its right neighbor from the match on; else no walk runs.
// Schedule: the same removal walk if the task is queued, then an insert walk that
// carries the new entry down the chain one cell per cycle, swapping it in ahead of the
// first later entry.
// Requests are taken only while no walk is running and the result register is free
// or being drained; a stalled rsp_tready holds the result and blocks new requests.
// Reset empties the queue by clearing each cell's valid bit; slot payload needs no clearing.
module timer_event_queue_core
   import tmq_pkg::*;
#(
   parameter int unsigned NUM_TASKS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // task_id[3:0], due_time[35:4], action_code[51:36], context_word[83:52],
   // flag_bits[115:84], now_time[147:116], zero pad
   input  logic [151:0] req_tdata,
   input  logic [1:0]   req_tuser,  // req_type[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // fired_task[3:0], fired_action[19:4], fired_context[51:20], fired_flags[83:52],
   // next_time[115:84], zero pad
   output logic [119:0] rsp_tdata,
   output logic [1:0]   rsp_tuser   // was_queued[0], fired[1]
);

   localparam int unsigned IDX_W = $clog2(NUM_TASKS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REMOVE,
      ST_INSERT,
      ST_RESP
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               mode_ff, mode_in;
   entry_type          carry_ff, carry_in;
   logic [ID_W-1:0]    task_ff, task_in;
   logic               sched_ff, sched_in;
   logic [ID_COUNT-1:0] queued_ff, queued_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [119:0]       rsp_data_ff, rsp_data_in;
   logic [1:0]         rsp_user_ff, rsp_user_in;

   entry_type          cell_q [NUM_TASKS];
   cell_ctl_type       cell_ctl [NUM_TASKS];
   logic [NUM_TASKS-1:0] valid_vec;

   logic [1:0]  r_type;
   logic [3:0]  r_task;
   logic [31:0] r_due, r_context, r_flags, r_now;
   logic [15:0] r_action;
   logic        accept, out_free, in_range, pop, swap, match;
   entry_type   cur, head, new_entry;
   logic [31:0] head_wait;

   assign r_task    = req_tdata[3:0];
   assign r_due     = req_tdata[35:4];
   assign r_action  = req_tdata[51:36];
   assign r_context = req_tdata[83:52];
   assign r_flags   = req_tdata[115:84];
   assign r_now     = req_tdata[147:116];
   assign r_type    = req_tuser;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign in_range   = 32'(r_task) < NUM_TASKS;

   assign cur  = cell_q[idx_ff];
   assign head = cell_q[0];
   assign head_wait = r_now - head.due;
   assign match = cur.valid && (cur.id == task_ff);
   assign swap  = mode_ff || !cur.valid || is_before(carry_ff.due, cur.due);
   assign pop   = accept && (r_type == REQ_STEP) && head.valid && !head_wait[31];

   always_comb begin
      new_entry.valid        = 1'b1;
      new_entry.id           = r_task;
      new_entry.due          = r_due;
      new_entry.action       = r_action;
      new_entry.context_word = r_context;
      new_entry.flags        = r_flags;
   end

   generate
      for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
         entry_type next_e;
         if (i == NUM_TASKS - 1) begin : g_tail
            assign next_e = '0;
         end else begin : g_mid
            assign next_e = cell_q[i+1];
         end
         assign cell_ctl[i].load_next = pop ||
            ((state_ff == ST_REMOVE) && (idx_ff == IDX_W'(i)) && (mode_ff || match));
         assign cell_ctl[i].load_carry =
            (state_ff == ST_INSERT) && (idx_ff == IDX_W'(i)) && swap;
         tmq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (cell_ctl[i]),
            .next_entry  (next_e),
            .carry_entry (carry_ff),
            .entry       (cell_q[i])
         );
         assign valid_vec[i] = cell_q[i].valid;
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      mode_in      = mode_ff;
      carry_in     = carry_ff;
      task_in      = task_ff;
      sched_in     = sched_ff;
      queued_in    = queued_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in   = '0;
               mode_in  = 1'b0;
               task_in  = r_task;
               carry_in = new_entry;
               sched_in = (r_type == REQ_SCHEDULE);
               rsp_data_in  = '0;
               rsp_user_in  = '0;
               case (r_type)
                  REQ_SCHEDULE, REQ_CANCEL: begin
                     if (!in_range) begin
                        rsp_valid_in = 1'b1;
                     end else if (queued_ff[r_task]) begin
                        state_in = ST_REMOVE;
                     end else if (r_type == REQ_SCHEDULE) begin
                        state_in = ST_INSERT;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  REQ_STEP: begin
                     rsp_valid_in = 1'b1;
                     if (!head.valid) begin
                        rsp_data_in[115:84] = r_now + EMPTY_HALF;
                     end else if (head_wait[31]) begin
                        rsp_data_in[115:84] = head.due;
                     end else begin
                        queued_in[head.id]  = 1'b0;
                        rsp_user_in[1]      = 1'b1;
                        rsp_data_in[3:0]    = head.id;
                        rsp_data_in[19:4]   = head.action;
                        rsp_data_in[51:20]  = head.context_word;
                        rsp_data_in[83:52]  = head.flags;
                        rsp_data_in[115:84] = r_now;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_REMOVE: begin
            if (match) begin
               mode_in = 1'b1;
            end
            if (idx_ff == LAST_IDX) begin
               queued_in[task_ff] = 1'b0;
               rsp_user_in[0] = 1'b1;
               idx_in  = '0;
               mode_in = 1'b0;
               state_in = sched_ff ? ST_INSERT : ST_RESP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_INSERT: begin
            if (swap) begin
               carry_in = cur;
               mode_in  = 1'b1;
            end
            if (idx_ff == LAST_IDX) begin
               queued_in[task_ff] = 1'b1;
               state_in = ST_RESP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         mode_ff      <= 1'b0;
         queued_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         mode_ff      <= mode_in;
         queued_ff    <= queued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      carry_ff    <= carry_in;
      task_ff     <= task_in;
      sched_ff    <= sched_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // between requests the number of queued flags equals the number of occupied cells
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ($countones(queued_ff) == $countones(valid_vec)))
      else $error("queued flags and occupied cells disagree");

   // between requests an empty head cell means cell 1 is empty too
   a_packed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !cell_q[0].valid) |-> !cell_q[1].valid)
      else $error("hole at queue head");

   // a result never reports both a fired task and a prior queue state
   a_fired_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("fired and was_queued both set");

endmodule
